// File: design/pel_pkg.sv
// ----------------------------------------------------------------------------
// pel_pkg
// Shared types, constants and helpers of the peak envelope limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pel_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_IDX_W     = 3;
   localparam int SAMPLE_W     = 24;
   localparam int MAG_W        = 32;
   localparam int COEF_W       = 24;
   localparam int DIV_STEPS    = 24;
   localparam int CSR_IDX_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_COEFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEFF = 3'd4;

   typedef struct packed {
      logic [3:0]        channel_count;
      logic [COEF_W-1:0] input_gain;
      logic [COEF_W-1:0] ceiling_level;
      logic [COEF_W-1:0] attack_coeff;
      logic [COEF_W-1:0] release_coeff;
   } cfg_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0]            neg;
      logic [MAX_CHANNELS-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]                   peak;
   } frame_type;

   // Restore the sign and saturate to 24 bits.
   function automatic logic [SAMPLE_W-1:0] sat_out(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
      logic [SAMPLE_W-1:0] mm;
      if (neg) begin
         mm = (mag > 32'd8388608) ? 24'h800000 : mag[SAMPLE_W-1:0];
         return ~mm + 24'd1;
      end
      return (mag > 32'd8388607) ? 24'h7FFFFF : mag[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: design/pel_if.sv
// ----------------------------------------------------------------------------
// pel_if
// Handshake channels of the peak envelope limiter: frames, results, CSR.
// ----------------------------------------------------------------------------
`default_nettype none

interface pel_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample_0;
   logic signed [23:0] sample_1;
   logic signed [23:0] sample_2;
   logic signed [23:0] sample_3;
   logic signed [23:0] sample_4;
   logic signed [23:0] sample_5;
   logic signed [23:0] sample_6;
   logic signed [23:0] sample_7;
   modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, input ready);
   modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface pel_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] out_0;
   logic signed [23:0] out_1;
   logic signed [23:0] out_2;
   logic signed [23:0] out_3;
   logic signed [23:0] out_4;
   logic signed [23:0] out_5;
   logic signed [23:0] out_6;
   logic signed [23:0] out_7;
   logic               limiting;
   modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5,
                   out_6, out_7, limiting, input ready);
   modport sink   (input valid, out_0, out_1, out_2, out_3, out_4, out_5,
                   out_6, out_7, limiting, output ready);
endinterface

interface pel_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/peak_envelope_limiter.sv
// ----------------------------------------------------------------------------
// peak_envelope_limiter
// Multichannel peak limiter with attack/release envelope and ceiling gain.
// ----------------------------------------------------------------------------
// The front accepts a frame, makes 8 gain multiplies (one channel a cycle) and
//   pushes it into the queue; the back pops it and runs the envelope update, the
//   ceiling check, a 24-step restoring divide when limiting, 8 scaling multiplies
//   and the output load.
// Throughput is set by the back's divider and single shared scaling multiplier;
//   the front runs ahead through a 2-deep queue.
// Reset: synchronous; clears the envelope and registers to their defaults.
`default_nettype none

module peak_envelope_limiter
   import pel_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pel_req_if.sink   req_ch,
   pel_rsp_if.source rsp_ch,
   pel_csr_if.sink   csr_ch
);

   cfg_type   cfg_ff;
   frame_type push_data;
   frame_type head;
   logic      push_valid;
   logic      q_full;
   logic      q_empty;
   logic      pop;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= 4'd2;
         cfg_ff.input_gain    <= 24'd65536;
         cfg_ff.ceiling_level <= 24'd7476354;
         cfg_ff.attack_coeff  <= 24'd16431303;
         cfg_ff.release_coeff <= 24'd16773721;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_CHANNEL_COUNT: cfg_ff.channel_count <= csr_ch.data[3:0];
            CSR_INPUT_GAIN:    cfg_ff.input_gain    <= csr_ch.data;
            CSR_CEILING_LEVEL: cfg_ff.ceiling_level <= csr_ch.data;
            CSR_ATTACK_COEFF:  cfg_ff.attack_coeff  <= csr_ch.data;
            CSR_RELEASE_COEFF: cfg_ff.release_coeff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   pel_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   pel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty)
   );

   pel_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// File: design/pel_front.sv
// ----------------------------------------------------------------------------
// pel_front
// Accepts a frame, applies input gain one channel a cycle, finds the peak.
// ----------------------------------------------------------------------------
`default_nettype none

module pel_front
   import pel_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   pel_req_if.sink    req_ch,
   input  wire cfg_type cfg,
   output logic       push_valid,
   output frame_type  push_data,
   input  wire logic  q_full
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type                       state_ff, state_in;
   logic [SAMPLE_W-1:0]              smp_ff [MAX_CHANNELS];
   logic [CH_IDX_W-1:0]              idx_ff, idx_in;
   logic [3:0]                       used_ff;
   frame_type                        frm_ff;
   logic [SAMPLE_W-1:0]              raw;
   logic [SAMPLE_W-1:0]              absv;
   logic [2*COEF_W-1:0]              prod;
   logic [MAG_W-1:0]                 mag;
   logic                             in_use;

   assign req_ch.ready = (state_ff == F_IDLE);
   assign push_valid   = (state_ff == F_PUSH);
   assign push_data    = frm_ff;

   always_comb begin
      raw    = smp_ff[idx_ff];
      absv   = raw[SAMPLE_W-1] ? (~raw + 24'd1) : raw;
      prod   = {24'd0, absv} * {24'd0, cfg.input_gain};
      mag    = prod[MAG_W+15:16];
      in_use = ({1'b0, idx_ff} < used_ff);
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         F_IDLE: begin
            idx_in = '0;
            if (req_ch.valid) state_in = F_MUL;
         end
         F_MUL: begin
            idx_in = idx_ff + 3'd1;
            if (idx_ff == CH_IDX_W'(MAX_CHANNELS - 1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_ch.valid) begin
         smp_ff[0] <= req_ch.sample_0;
         smp_ff[1] <= req_ch.sample_1;
         smp_ff[2] <= req_ch.sample_2;
         smp_ff[3] <= req_ch.sample_3;
         smp_ff[4] <= req_ch.sample_4;
         smp_ff[5] <= req_ch.sample_5;
         smp_ff[6] <= req_ch.sample_6;
         smp_ff[7] <= req_ch.sample_7;
         used_ff   <= (cfg.channel_count > 4'd8) ? 4'd8 : cfg.channel_count;
         frm_ff.peak <= '0;
      end else if (state_ff == F_MUL) begin
         // unused channels carry zero so they read back as zero output
         frm_ff.neg[idx_ff] <= raw[SAMPLE_W-1];
         frm_ff.mag[idx_ff] <= in_use ? mag : '0;
         if (in_use && mag > frm_ff.peak) frm_ff.peak <= mag;
      end
   end

endmodule

`default_nettype wire

// File: design/pel_queue.sv
// ----------------------------------------------------------------------------
// pel_queue
// Two-entry frame queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pel_queue
   import pel_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire frame_type push_data,
   output logic           full,
   input  wire logic      pop,
   output frame_type      head,
   output logic           empty
);

   frame_type  q_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= push_data;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !do_pop) else $error("pop from empty queue");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wr_ff != rd_ff)) else $error("queue pointers out of step");

endmodule

`default_nettype wire

// File: design/pel_back.sv
// ----------------------------------------------------------------------------
// pel_back
// Envelope update, iterative gain divide, per-channel scaling and output.
// ----------------------------------------------------------------------------
`default_nettype none

module pel_back
   import pel_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire frame_type head,
   input  wire logic      q_empty,
   output logic           pop,
   pel_rsp_if.source      rsp_ch
);

   typedef enum logic [7:0] {
      B_IDLE  = 8'b0000_0001,
      B_ENV1  = 8'b0000_0010,
      B_ENV2  = 8'b0000_0100,
      B_ENV3  = 8'b0000_1000,
      B_LIM   = 8'b0001_0000,
      B_DIV   = 8'b0010_0000,
      B_SCALE = 8'b0100_0000,
      B_DONE  = 8'b1000_0000
   } bstate_type;

   bstate_type          state_ff, state_in;
   frame_type           frm_ff;
   logic [MAG_W-1:0]    env_ff;
   logic                attack_ff;
   logic                lim_ff;
   logic [55:0]         p1_ff;
   logic [56:0]         p2_ff;
   logic [57:0]         env_sum;
   logic [MAG_W-1:0]    rem_ff;
   logic [COEF_W-1:0]   q_ff;
   logic [4:0]          cnt_ff;
   logic [CH_IDX_W-1:0] ch_ff;
   logic [SAMPLE_W-1:0] res_ff [MAX_CHANNELS];
   logic [SAMPLE_W-1:0] out_ff [MAX_CHANNELS];
   logic                out_lim_ff;
   logic                out_valid_ff;
   logic [MAG_W:0]      trial;
   logic [55:0]         sprod;
   logic [MAG_W-1:0]    smag;
   logic                load_out;

   assign pop      = (state_ff == B_IDLE) && !q_empty;
   assign load_out = (state_ff == B_DONE) && (!out_valid_ff || rsp_ch.ready);
   assign env_sum  = {2'b00, p1_ff} + {1'b0, p2_ff};
   assign trial    = {rem_ff, 1'b0};

   always_comb begin
      sprod = {24'd0, frm_ff.mag[ch_ff]} * {32'd0, q_ff};
      smag  = lim_ff ? sprod[55:24] : frm_ff.mag[ch_ff];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (!q_empty) state_in = B_ENV1;
         B_ENV1:  state_in = B_ENV2;
         B_ENV2:  state_in = B_ENV3;
         B_ENV3:  state_in = B_LIM;
         B_LIM:   state_in = (env_ff > {8'd0, cfg.ceiling_level}) ? B_DIV : B_SCALE;
         B_DIV:   if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = B_SCALE;
         B_SCALE: if (ch_ff == CH_IDX_W'(MAX_CHANNELS - 1)) state_in = B_DONE;
         B_DONE:  if (load_out) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         env_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_ENV3) env_ff <= env_sum[55:24];
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_ch.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            frm_ff <= head;
         end
         B_ENV1: begin
            attack_ff <= (frm_ff.peak > env_ff);
            p1_ff <= {24'd0, (frm_ff.peak > env_ff) ? cfg.attack_coeff : cfg.release_coeff}
                     * {24'd0, env_ff};
         end
         B_ENV2: begin
            p2_ff <= attack_ff ? ({32'd0, 25'h1000000 - {1'b0, cfg.attack_coeff}}
                                  * {25'd0, frm_ff.peak}) : '0;
         end
         B_LIM: begin
            // quotient bits above 24 are zero, so start from the ceiling
            lim_ff <= (env_ff > {8'd0, cfg.ceiling_level});
            rem_ff <= {8'd0, cfg.ceiling_level};
            q_ff   <= '0;
            cnt_ff <= '0;
            ch_ff  <= '0;
         end
         B_DIV: begin
            cnt_ff <= cnt_ff + 5'd1;
            if (trial >= {1'b0, env_ff}) begin
               rem_ff <= MAG_W'(trial - {1'b0, env_ff});
               q_ff   <= {q_ff[COEF_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[MAG_W-1:0];
               q_ff   <= {q_ff[COEF_W-2:0], 1'b0};
            end
         end
         B_SCALE: begin
            res_ff[ch_ff] <= sat_out(frm_ff.neg[ch_ff], smag);
            ch_ff <= ch_ff + 3'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff     <= res_ff;
         out_lim_ff <= lim_ff;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_0    = out_ff[0];
   assign rsp_ch.out_1    = out_ff[1];
   assign rsp_ch.out_2    = out_ff[2];
   assign rsp_ch.out_3    = out_ff[3];
   assign rsp_ch.out_4    = out_ff[4];
   assign rsp_ch.out_5    = out_ff[5];
   assign rsp_ch.out_6    = out_ff[6];
   assign rsp_ch.out_7    = out_ff[7];
   assign rsp_ch.limiting = out_lim_ff;

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (cnt_ff < 5'(DIV_STEPS))) else $error("divide overrun");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (rem_ff < env_ff)) else $error("remainder not below divisor");
   a_pop_once: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == B_ENV1)) else $error("pop without envelope step");

endmodule

`default_nettype wire
